FILE: design/dtt_pkg.sv
// Shared types and constants for the due-time task table.
package dtt_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int SLOT_CMP_W = 9;
  localparam logic [31:0] DUE_HALF = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_PAUSE    = 3'd2,
    ACT_RESUME   = 3'd3,
    ACT_POLL     = 3'd4,
    ACT_COMPLETE = 3'd5,
    ACT_CLEAR    = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RMW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] due;
    logic        run;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: design/due_task_timer_table.sv
// Due-time task table: slot store in RAM with a sequenced read-modify-write controller.
//
// Input channel (in_valid / in_stall) carries one command per transfer: add, remove,
// pause, resume, poll due, complete or clear all. Output channel (out_valid / out_stall)
// returns exactly one result per command: status, result_slot and result_handle.
// Commands are handled one at a time; in_stall is high while a command is in work.
// Slot contents live in one RAM with a registered read; a valid bit per slot marks
// entries written since reset or since the slot was freed, and unwritten slots read
// as empty.
// Add scans every slot through the RAM read port, one read per cycle. Poll scans
// round-robin from the saved position and stops at the first due slot. Pause, resume
// and complete read one slot and update it only if it holds a task; remove, clear all
// and unknown actions read no slot. Reset empties the table at once (valid bits
// cleared) and zeroes the scan position; no clearing pass is needed. When the
// receiver stalls, the result is held in the output register and a finished command
// waits for it to drain before the next command is taken.
module due_task_timer_table
  import dtt_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [15:0] handle,
  input  logic [3:0]  slot,
  input  logic [31:0] delay,
  input  logic [31:0] now,
  input  logic [31:0] interval,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  result_slot,
  output logic [15:0] result_handle
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  state_t state, state_next;

  // command registers
  logic [2:0]       act_r;
  logic [15:0]      handle_r;
  logic [31:0]      now_r;
  logic [31:0]      add_due_r;
  logic [31:0]      cmp_due_r;
  logic             ival_pos_r;

  // scan registers
  logic [IDX_W-1:0] scan_addr;
  logic [CNT_W-1:0] issue_cnt;
  logic             rd_vld;
  logic             rd_last;
  logic [IDX_W-1:0] rd_addr;
  logic             dup_q;
  logic             found_q;
  logic [IDX_W-1:0] free_q;
  logic [IDX_W-1:0] scan_pos;

  logic [TASK_SLOTS-1:0] vld;

  status_t          res_status;
  logic [3:0]       res_slot;
  logic [15:0]      res_handle;

  // RAM interface
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENTRY_W-1:0] mem_q;

  logic             accept;
  logic             slot_ok;
  logic [IDX_W-1:0] slot_idx;
  entry_t           rd_ent;
  logic             issue;
  logic             match_dup;
  logic             free_hit;
  logic             dup_now;
  logic             found_now;
  logic [IDX_W-1:0] free_now;
  logic             due_hit;
  logic             scan_end;
  logic             out_load;
  logic [31:0]      due_diff;
  logic             vld_clr_one;
  logic [IDX_W-1:0] vld_clr_idx;

  dtt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TASK_SLOTS),
    .AW   (IDX_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(mem_raddr),
    .rd_data(mem_q)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign slot_ok  = SLOT_CMP_W'(slot) < SLOT_CMP_W'(TASK_SLOTS);
  assign slot_idx = IDX_W'(slot);

  // unwritten or freed slots read as empty
  assign rd_ent   = vld[rd_addr] ? entry_t'(mem_q) : '0;
  assign issue    = (state == S_SCAN) && (issue_cnt != CNT_W'(TASK_SLOTS));

  assign match_dup = rd_vld && (rd_ent.handle == handle_r);
  assign free_hit  = rd_vld && (rd_ent.handle == 16'd0) && !found_q;
  assign dup_now   = dup_q || match_dup;
  assign found_now = found_q || free_hit;
  assign free_now  = found_q ? free_q : rd_addr;
  assign due_diff  = rd_ent.due - now_r;
  assign due_hit   = rd_vld && rd_ent.run && (rd_ent.handle != 16'd0) &&
                     (due_diff > DUE_HALF);
  assign scan_end  = rd_vld && rd_last;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next  = state;
    mem_re      = 1'b0;
    mem_raddr   = scan_addr;
    mem_we      = 1'b0;
    mem_waddr   = rd_addr;
    mem_wdata   = rd_ent;
    vld_clr_one = 1'b0;
    vld_clr_idx = slot_idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_ADD, ACT_POLL: state_next = S_SCAN;
            ACT_PAUSE, ACT_RESUME, ACT_COMPLETE: begin
              if (slot_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = slot_idx;
                state_next = S_RMW;
              end else begin
                state_next = S_DONE;
              end
            end
            ACT_REMOVE: begin
              vld_clr_one = slot_ok;
              state_next  = S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        mem_re = issue;
        if (act_r == ACT_POLL) begin
          if (due_hit || scan_end) begin
            state_next = S_DONE;
          end
        end else if (scan_end) begin
          state_next = S_DONE;
          if (!dup_now && found_now) begin
            mem_we    = 1'b1;
            mem_waddr = free_now;
            mem_wdata = '{handle: handle_r, due: add_due_r, run: 1'b1};
          end
        end
      end
      S_RMW: begin
        state_next = S_DONE;
        if (act_r == ACT_PAUSE) begin
          mem_wdata.run = 1'b0;
          mem_we        = (rd_ent.handle != 16'd0);
        end else if (rd_ent.handle != 16'd0) begin
          if (act_r == ACT_RESUME) begin
            mem_wdata.run = 1'b1;
            mem_we        = 1'b1;
          end else if (ival_pos_r) begin
            mem_wdata.due = cmp_due_r;
            mem_we        = 1'b1;
          end else begin
            // interval not positive: free the slot
            vld_clr_one = 1'b1;
            vld_clr_idx = rd_addr;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      scan_pos  <= '0;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (action == ACT_CLEAR)) begin
        vld <= '0;
      end else begin
        if (vld_clr_one) begin
          vld[vld_clr_idx] <= 1'b0;
        end
        if (mem_we) begin
          vld[mem_waddr] <= 1'b1;
        end
      end
      if (state == S_SCAN) begin
        rd_vld <= issue;
      end else begin
        rd_vld <= 1'b0;
      end
      if ((state == S_SCAN) && (act_r == ACT_POLL) && due_hit) begin
        scan_pos <= (rd_addr == LAST_IDX) ? '0 : rd_addr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and scan datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r      <= action;
      handle_r   <= handle;
      now_r      <= now;
      add_due_r  <= now + delay;
      cmp_due_r  <= now + interval;
      ival_pos_r <= (interval != 32'd0) && !interval[31];
      dup_q      <= (handle == 16'd0);
      found_q    <= 1'b0;
      free_q     <= '0;
      issue_cnt  <= '0;
      scan_addr  <= (action == ACT_POLL) ? scan_pos : '0;
      rd_addr    <= slot_idx;
      rd_last    <= 1'b0;
      res_status <= ST_OK;
      res_slot   <= '0;
      res_handle <= '0;
    end
    if (state == S_SCAN) begin
      if (issue) begin
        scan_addr <= (scan_addr == LAST_IDX) ? '0 : scan_addr + 1'b1;
        issue_cnt <= issue_cnt + 1'b1;
        rd_addr   <= scan_addr;
        rd_last   <= (issue_cnt == CNT_W'(TASK_SLOTS - 1));
      end
      dup_q   <= dup_now;
      found_q <= found_now;
      free_q  <= free_now;
      if (act_r == ACT_POLL) begin
        if (due_hit) begin
          res_slot   <= 4'(rd_addr);
          res_handle <= rd_ent.handle;
        end else if (scan_end) begin
          res_status <= ST_NONE;
        end
      end else if (scan_end) begin
        if (dup_now) begin
          res_status <= ST_DUP;
        end else if (!found_now) begin
          res_status <= ST_FULL;
        end else begin
          res_slot <= 4'(free_now);
        end
      end
    end
    if (out_load) begin
      status        <= res_status;
      result_slot   <= res_slot;
      result_handle <= res_handle;
    end
  end

endmodule

FILE: design/dtt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: bench/due_task_timer_table_tb.sv
// Self-checking testbench for the due-time task table: predictor, scoreboard and drivers.
`timescale 1ns / 100ps

module due_task_timer_table_tb
  import dtt_pkg::*;
;

  typedef struct {
    logic [2:0]  act;
    logic [15:0] handle;
    logic [3:0]  slot;
    logic [31:0] delay;
    logic [31:0] now;
    logic [31:0] interval;
  } table_command_t;

  typedef struct {
    status_t     status;
    logic [3:0]  slot;
    logic [15:0] handle;
  } table_reply_t;

  // Shadow copy of the slot table; predicts one reply per command and checks in order.
  class task_table_tracker;
    logic [15:0]  handles [TASK_SLOTS_DEF];
    logic [31:0]  dues [TASK_SLOTS_DEF];
    bit           running [TASK_SLOTS_DEF];
    int           scan_pos;
    int           last_due_slot;
    table_reply_t expected_replies [$];
    int mismatches, replies_checked;
    int adds_placed, dup_rejects, full_rejects, due_hits, none_due;

    function new();
      int i;
      for (i = 0; i < TASK_SLOTS_DEF; i++) free_slot(i);
      scan_pos = 0;
      last_due_slot = -1;
    endfunction

    function void free_slot(int s);
      handles[s] = '0;
      dues[s] = '0;
      running[s] = 1'b0;
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction

    // Random occupied slot, or any slot when the table is empty.
    function logic [3:0] busy_slot();
      logic [3:0] cand [$];
      int i;
      for (i = 0; i < TASK_SLOTS_DEF; i++)
        if (handles[i] != 0) cand.push_back(4'(i));
      if (cand.size() == 0) return 4'($urandom_range(0, TASK_SLOTS_DEF - 1));
      return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function void note_command(table_command_t c);
      table_reply_t r;
      bit dup, found, hit;
      int free_idx, i, s;
      logic [31:0] lag;
      r.status = ST_OK;
      r.slot = '0;
      r.handle = '0;
      case (c.act)
        ACT_ADD: begin
          dup = (c.handle == 0);
          found = 1'b0;
          free_idx = 0;
          for (i = 0; i < TASK_SLOTS_DEF; i++) begin
            if (handles[i] == c.handle) dup = 1'b1;
            if (!found && handles[i] == 0) begin
              found = 1'b1;
              free_idx = i;
            end
          end
          if (dup) begin
            r.status = ST_DUP;
            dup_rejects++;
          end else if (!found) begin
            r.status = ST_FULL;
            full_rejects++;
          end else begin
            handles[free_idx] = c.handle;
            dues[free_idx] = c.now + c.delay;
            running[free_idx] = 1'b1;
            r.slot = 4'(free_idx);
            adds_placed++;
          end
        end
        ACT_REMOVE: free_slot(c.slot);
        ACT_PAUSE: running[c.slot] = 1'b0;
        ACT_RESUME: if (handles[c.slot] != 0) running[c.slot] = 1'b1;
        ACT_POLL: begin
          hit = 1'b0;
          last_due_slot = -1;
          for (i = 0; i < TASK_SLOTS_DEF && !hit; i++) begin
            s = (scan_pos + i) % TASK_SLOTS_DEF;
            lag = dues[s] - c.now;
            // wrap-safe: due once the due time lies in the past half of the circle
            if (running[s] && handles[s] != 0 && lag > DUE_HALF) begin
              hit = 1'b1;
              r.slot = 4'(s);
              r.handle = handles[s];
              scan_pos = (s + 1) % TASK_SLOTS_DEF;
              last_due_slot = s;
            end
          end
          if (hit) due_hits++;
          else begin
            r.status = ST_NONE;
            none_due++;
          end
        end
        ACT_COMPLETE: begin
          if (handles[c.slot] != 0) begin
            if ($signed(c.interval) > 0) dues[c.slot] = c.now + c.interval;
            else free_slot(c.slot);
          end
        end
        ACT_CLEAR: for (i = 0; i < TASK_SLOTS_DEF; i++) free_slot(i);
        default: ;
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [1:0] st, logic [3:0] rs, logic [15:0] rh);
      table_reply_t e;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status=%0d slot=%0d handle=%h",
                   $realtime, st, rs, rh);
        return;
      end
      e = expected_replies.pop_front();
      replies_checked++;
      if (st !== e.status || rs !== e.slot || rh !== e.handle) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: result %0d mismatch: status exp %0d got %0d, ",
                    "slot exp %0d got %0d, handle exp %h got %h"},
                   $realtime, replies_checked, e.status, st, e.slot, rs, e.handle, rh);
      end
    endfunction
  endclass

  localparam logic [2:0] ACT_UNDEF = 3'd7;
  localparam int ITEMS_TOTAL = 1300;
  localparam int TAIL_ITEMS = 150;
  localparam int LONG_HOLD = 80;
  localparam int DRAIN_CYCLES = 2 * (TASK_SLOTS_DEF + 3);
  localparam int IDLE_LIMIT = 2000;

  bit          clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  action;
  logic [15:0] handle;
  logic [3:0]  slot;
  logic [31:0] delay;
  logic [31:0] now;
  logic [31:0] interval;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [3:0]  result_slot;
  logic [15:0] result_handle;

  task_table_tracker tracker;
  logic [31:0] tick_now;
  bit          tx_gaps, rx_bursts, hold_long;
  int          items_sent, episode, quiet_cycles, leftover;
  int          act_count [8];

  due_task_timer_table DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .handle(handle), .slot(slot),
    .delay(delay), .now(now), .interval(interval),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_slot(result_slot), .result_handle(result_handle)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_reply(status, result_slot, result_handle);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic issue(input logic [2:0] act, input logic [15:0] h, input logic [3:0] s,
                       input logic [31:0] d, input logic [31:0] n, input logic [31:0] iv);
    table_command_t c;
    int gap;
    c.act = act;
    c.handle = h;
    c.slot = s;
    c.delay = d;
    c.now = n;
    c.interval = iv;
    gap = (tx_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    handle <= h;
    slot <= s;
    delay <= d;
    now <= n;
    interval <= iv;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.note_command(c);
    items_sent++;
    act_count[act]++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_handle();
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1, 2, 3: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [31:0] pick_delay();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return DUE_HALF + 32'($urandom_range(0, 2)) - 32'd1;
      default: return 32'($urandom_range(0, 1500));
    endcase
  endfunction

  function automatic logic [31:0] pick_interval();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd0 - 32'($urandom_range(1, 1000));
      2: return $urandom;
      3: return $urandom | 32'h8000_0000;
      default: return 32'($urandom_range(1, 1500));
    endcase
  endfunction

  // Scheduler-like mix, mostly adds and polls; a due poll usually precedes its complete.
  task automatic random_command();
    int pick;
    logic [2:0] act;
    logic [15:0] h;
    logic [3:0] s;
    logic [31:0] d, iv;
    pick = $urandom_range(0, 99);
    h = 16'($urandom);
    s = 4'($urandom);
    d = $urandom;
    iv = $urandom;
    tick_now = tick_now + (($urandom_range(0, 19) == 0) ? $urandom_range(0, 100000)
                                                         : $urandom_range(0, 400));
    if (pick < 30) begin
      act = ACT_ADD;
      h = pick_handle();
      d = pick_delay();
    end else if (pick < 60) begin
      act = ACT_POLL;
    end else if (pick < 72) begin
      act = ACT_COMPLETE;
      s = tracker.busy_slot();
      iv = pick_interval();
    end else if (pick < 79) begin
      act = ACT_PAUSE;
      s = tracker.busy_slot();
    end else if (pick < 87) begin
      act = ACT_RESUME;
      s = tracker.busy_slot();
    end else if (pick < 94) begin
      act = ACT_REMOVE;
      if ($urandom_range(0, 1) == 0) s = tracker.busy_slot();
    end else if (pick < 96) begin
      act = ACT_CLEAR;
    end else if (pick < 99) begin
      act = 3'($urandom_range(0, 7));
    end else begin
      act = ACT_UNDEF;
    end
    issue(act, h, s, d, tick_now, iv);
    if (act == ACT_POLL && tracker.last_due_slot >= 0 && $urandom_range(0, 9) < 8)
      issue(ACT_COMPLETE, 16'($urandom), 4'(tracker.last_due_slot), $urandom, tick_now,
            pick_interval());
  endtask

  // Wipe the table, overfill it, then poll a few times.
  task automatic fill_table();
    int k;
    logic [15:0] base;
    base = 16'($urandom_range(100, 60000));
    issue(ACT_CLEAR, 16'($urandom), 4'($urandom), $urandom, tick_now, $urandom);
    for (k = 0; k < TASK_SLOTS_DEF + 2; k++) begin
      tick_now = tick_now + 32'($urandom_range(0, 50));
      issue(ACT_ADD, base + 16'(k), 4'($urandom), pick_delay(), tick_now, $urandom);
    end
    issue(ACT_ADD, base + 16'd3, 4'($urandom), pick_delay(), tick_now, $urandom);
    repeat (6) begin
      tick_now = tick_now + 32'($urandom_range(0, 800));
      issue(ACT_POLL, 16'($urandom), 4'($urandom), $urandom, tick_now, $urandom);
    end
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    in_valid = 1'b0;
    action = '0;
    handle = '0;
    slot = '0;
    delay = '0;
    now = '0;
    interval = '0;
    tx_gaps = 1'b0;
    rx_bursts = 1'b0;
    hold_long = 1'b0;
    tick_now = 32'd1000;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: boundaries of the due test, wrapped due times and the ignored cases
    issue(ACT_ADD, 16'd0, 4'd0, 32'd0, 32'd1000, 32'd0);
    issue(ACT_ADD, 16'hFFFF, 4'd0, 32'd0, 32'd1000, 32'd0);
    issue(ACT_ADD, 16'hFFFF, 4'd0, 32'd5, 32'd1000, 32'd0);
    issue(ACT_ADD, 16'd1, 4'd0, 32'hFFFF_FFFF, 32'd1000, 32'd0);
    issue(ACT_POLL, 16'd0, 4'd0, 32'd0, 32'd1000, 32'd0);
    issue(ACT_POLL, 16'd0, 4'd0, 32'd0, 32'd1001, 32'd0);
    issue(ACT_PAUSE, 16'd0, 4'd1, 32'd0, 32'd1001, 32'd0);
    issue(ACT_POLL, 16'd0, 4'd0, 32'd0, 32'd1001, 32'd0);
    issue(ACT_RESUME, 16'd0, 4'd1, 32'd0, 32'd1001, 32'd0);
    issue(ACT_COMPLETE, 16'd0, 4'd0, 32'd0, 32'd1001, 32'd500);
    issue(ACT_COMPLETE, 16'd0, 4'd1, 32'd0, 32'd1001, 32'd0);
    issue(ACT_POLL, 16'd0, 4'd0, 32'd0, 32'd1001, 32'd0);
    issue(ACT_ADD, 16'd2, 4'd0, DUE_HALF, 32'd1001, 32'd0);
    issue(ACT_POLL, 16'd0, 4'd0, 32'd0, 32'd1001, 32'd0);
    issue(ACT_ADD, 16'd3, 4'd0, 32'h8000_0000, 32'd1001, 32'd0);
    issue(ACT_POLL, 16'd0, 4'd0, 32'd0, 32'd1001, 32'd0);
    issue(ACT_COMPLETE, 16'd0, 4'd2, 32'd0, 32'd1001, 32'h8000_0000);
    issue(ACT_COMPLETE, 16'd0, 4'd5, 32'd0, 32'd1001, 32'd10);
    issue(ACT_RESUME, 16'd0, 4'd7, 32'd0, 32'd1001, 32'd0);
    issue(ACT_REMOVE, 16'd0, 4'd0, 32'd0, 32'd1001, 32'd0);
    issue(ACT_UNDEF, 16'hFFFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(ACT_PAUSE, 16'd0, 4'hF, 32'd0, 32'd1001, 32'd0);
    issue(ACT_CLEAR, 16'd0, 4'd0, 32'd0, 32'd1001, 32'd0);
    issue(ACT_POLL, 16'd0, 4'd0, 32'd0, 32'd1001, 32'd0);

    episode = 0;
    while (items_sent < ITEMS_TOTAL) begin
      tx_gaps = (items_sent < ITEMS_TOTAL - TAIL_ITEMS) && ($urandom_range(0, 3) != 0);
      rx_bursts = (items_sent < ITEMS_TOTAL - TAIL_ITEMS) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0) tick_now = $urandom;
      // walk the clock across the 32-bit wrap
      if (episode == 4) tick_now = 32'hFFFF_F800;
      if (episode == 2) hold_long = 1'b1;
      if (episode == 6) begin
        go_quiet();
        while (tracker.outstanding() != 0) @(posedge clk);
      end
      if (episode == 1 || $urandom_range(0, 7) == 0) fill_table();
      else repeat ($urandom_range(20, 40)) random_command();
      episode++;
    end
    go_quiet();

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    leftover = tracker.outstanding();
    $display("Ran %0d commands (%0d add, %0d poll, %0d complete, %0d clear).",
             items_sent, act_count[ACT_ADD], act_count[ACT_POLL], act_count[ACT_COMPLETE],
             act_count[ACT_CLEAR]);
    $display({"%0d placed, %0d dup, %0d full, %0d due, %0d none due; ",
              "%0d results checked, %0d mismatches, %0d results missing."},
             tracker.adds_placed, tracker.dup_rejects, tracker.full_rejects,
             tracker.due_hits, tracker.none_due, tracker.replies_checked,
             tracker.mismatches, leftover);
    if (tracker.mismatches == 0 && leftover == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/dtt_pkg.sv
design/dtt_ram.sv
design/due_task_timer_table.sv
bench/due_task_timer_table_tb.sv
